@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL modules.
// Needs a clock named clock and a reset named reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define SFPR_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");

// Implication checked in the next cycle.
`define SFPR_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/sfpr_pkg.sv @@
// Types and constants of the segmented FIFO page replacement block.
// No dependencies.
package sfpr_pkg;

   localparam int PAGE_W      = 20;
   localparam int PAGE_LSB    = 12;
   localparam int ADDR_W      = 32;
   localparam int CFG_W       = 7;
   localparam int CNT_W       = 32;
   localparam int PROD_W      = 14;
   localparam int RECIP_SHIFT = 24;

   // ceil(2^24 / 100); exact for products below 2^14
   localparam logic [17:0] RECIP_K = 18'd167773;
   localparam logic [CFG_W-1:0] PCT_MAX = 7'd99;

   localparam logic [1:0] HIT_MISS      = 2'd0;
   localparam logic [1:0] HIT_PRIMARY   = 2'd1;
   localparam logic [1:0] HIT_SECONDARY = 2'd2;

   localparam logic CSR_TOTAL_FRAMES      = 1'b0;
   localparam logic CSR_SECONDARY_PERCENT = 1'b1;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic              dirty;
   } entry_type;

endpackage

@@ hw/rtl/segmented_fifo_page_replacement.sv @@
// Top level of the segmented FIFO page replacement block.
// Depends on sfpr_pkg, sfpr_ring and assert_macros.svh.
//
// Usage:
//   Request channel (req_valid / req_stall) carries one access: address and
//   write flag. Response channel (rsp_valid / rsp_stall) returns one result
//   per request: disk read/write flags, hit place and three saturating totals.
//   The csr_ port writes total_frames (index 0) and secondary_percent (1).
//   Each list lives in a ring memory; lookups scan it one entry a cycle.
//   From accept to rsp_valid a request runs the share step and the primary
//   scan, which a primary hit or a primary fill ends; when the primary list
//   is full, a demotion after a secondary miss adds the tail read, the scan
//   over the secondary list and the push, plus a secondary tail read for a
//   drop; a secondary hit at position J instead adds the scan and the LRU shift.
//   The memory scans set the time taken; one request is worked on at a time.
//   A new request is taken while the previous response waits to be taken.
//   Reset empties both lists, clears the totals and loads the register
//   defaults (64 frames, 50 percent). No clearing pass is needed.
//   While rsp_stall is high the response holds; a finished request then
//   waits until the response register frees.
module segmented_fifo_page_replacement
   import sfpr_pkg::*;
#(
   parameter int MAX_FRAMES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [ADDR_W-1:0] req_access_address,
   input  logic              req_is_write,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_disk_read,
   output logic              rsp_disk_write,
   output logic [1:0]        rsp_hit_place,
   output logic [CNT_W-1:0]  rsp_reads_so_far,
   output logic [CNT_W-1:0]  rsp_writes_so_far,
   output logic [CNT_W-1:0]  rsp_accesses_so_far,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [CFG_W-1:0]  csr_wdata
);

   `include "assert_macros.svh"

   localparam int AW = $clog2(MAX_FRAMES);
   localparam int UW = $clog2(MAX_FRAMES + 1);
   localparam int CW = (UW > CFG_W) ? UW : CFG_W;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SHARE    = 4'd1;
   localparam logic [3:0] ST_PSCAN    = 4'd2;
   localparam logic [3:0] ST_PTAIL    = 4'd3;
   localparam logic [3:0] ST_SSCAN    = 4'd4;
   localparam logic [3:0] ST_STAIL    = 4'd5;
   localparam logic [3:0] ST_SHIFT_RD = 4'd6;
   localparam logic [3:0] ST_SHIFT_WR = 4'd7;
   localparam logic [3:0] ST_PUSH     = 4'd8;
   localparam logic [3:0] ST_FINISH   = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [CFG_W-1:0]  frames_cfg_ff, frames_cfg_in;
   logic [CFG_W-1:0]  pct_cfg_ff, pct_cfg_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic              wflag_ff, wflag_in;
   logic [CFG_W-1:0]  frames_ff, frames_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [CFG_W-1:0]  sec_share_ff, sec_share_in;
   logic [CFG_W-1:0]  pri_share_ff, pri_share_in;
   logic [AW-1:0]     p_head_ff, p_head_in;
   logic [AW-1:0]     s_head_ff, s_head_in;
   logic [UW-1:0]     p_used_ff, p_used_in;
   logic [UW-1:0]     s_used_ff, s_used_in;
   logic [UW-1:0]     idx_ff, idx_in;
   logic [UW-1:0]     rd_idx_ff, rd_idx_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [UW-1:0]     sh_idx_ff, sh_idx_in;
   entry_type         tail_ff, tail_in;
   entry_type         pnew_ff, pnew_in;
   logic              dread_ff, dread_in;
   logic              dwrite_ff, dwrite_in;
   logic [1:0]        hit_ff, hit_in;
   logic [CNT_W-1:0]  reads_ff, reads_in;
   logic [CNT_W-1:0]  writes_ff, writes_in;
   logic [CNT_W-1:0]  accesses_ff, accesses_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_dread_ff, rsp_dread_in;
   logic              rsp_dwrite_ff, rsp_dwrite_in;
   logic [1:0]        rsp_hit_ff, rsp_hit_in;

   logic          p_rd_en, p_wr_en, p_wr_push;
   logic [AW-1:0] p_rd_idx, p_wr_idx;
   entry_type     p_wr_data, p_q;
   logic          s_rd_en, s_wr_en, s_wr_push;
   logic [AW-1:0] s_rd_idx, s_wr_idx;
   entry_type     s_wr_data, s_q;

   logic [CFG_W-1:0] frames_clamp;
   logic [CFG_W-1:0] pct_clamp;
   logic [31:0]      recip_prod;
   logic [CFG_W-1:0] sec_calc;
   logic [UW-1:0]    p_last, s_last, sh_next;
   logic [AW-1:0]    p_head_dec, s_head_dec;
   logic             req_take, rsp_load;

   sfpr_ring #(.MAX_FRAMES(MAX_FRAMES)) u_primary (
      .clock   (clock),
      .head    (p_head_ff),
      .rd_en   (p_rd_en),
      .rd_idx  (p_rd_idx),
      .rd_data (p_q),
      .wr_en   (p_wr_en),
      .wr_push (p_wr_push),
      .wr_idx  (p_wr_idx),
      .wr_data (p_wr_data)
   );

   sfpr_ring #(.MAX_FRAMES(MAX_FRAMES)) u_secondary (
      .clock   (clock),
      .head    (s_head_ff),
      .rd_en   (s_rd_en),
      .rd_idx  (s_rd_idx),
      .rd_data (s_q),
      .wr_en   (s_wr_en),
      .wr_push (s_wr_push),
      .wr_idx  (s_wr_idx),
      .wr_data (s_wr_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign rsp_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   assign p_last     = p_used_ff - UW'(1);
   assign s_last     = s_used_ff - UW'(1);
   assign sh_next    = sh_idx_ff + UW'(1);
   assign p_head_dec = (p_head_ff == '0) ? AW'(MAX_FRAMES - 1) : p_head_ff - AW'(1);
   assign s_head_dec = (s_head_ff == '0) ? AW'(MAX_FRAMES - 1) : s_head_ff - AW'(1);

   always_comb begin
      frames_clamp = (frames_cfg_ff == '0) ? CFG_W'(1) : frames_cfg_ff;
      if (CW'(frames_clamp) > CW'(MAX_FRAMES)) begin
         frames_clamp = CFG_W'(MAX_FRAMES);
      end
      pct_clamp  = (pct_cfg_ff > PCT_MAX) ? PCT_MAX : pct_cfg_ff;
      recip_prod = 32'(prod_ff) * 32'(RECIP_K);
      sec_calc   = CFG_W'(recip_prod >> RECIP_SHIFT);
   end

   always_comb begin
      frames_cfg_in = frames_cfg_ff;
      pct_cfg_in    = pct_cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_TOTAL_FRAMES:      frames_cfg_in = csr_wdata;
            CSR_SECONDARY_PERCENT: pct_cfg_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      page_in      = page_ff;
      wflag_in     = wflag_ff;
      frames_in    = frames_ff;
      prod_in      = prod_ff;
      sec_share_in = sec_share_ff;
      pri_share_in = pri_share_ff;
      p_head_in    = p_head_ff;
      s_head_in    = s_head_ff;
      p_used_in    = p_used_ff;
      s_used_in    = s_used_ff;
      idx_in       = idx_ff;
      rd_idx_in    = rd_idx_ff;
      rd_valid_in  = rd_valid_ff;
      sh_idx_in    = sh_idx_ff;
      tail_in      = tail_ff;
      pnew_in      = pnew_ff;
      dread_in     = dread_ff;
      dwrite_in    = dwrite_ff;
      hit_in       = hit_ff;
      p_rd_en      = 1'b0;
      p_rd_idx     = idx_ff[AW-1:0];
      p_wr_en      = 1'b0;
      p_wr_push    = 1'b0;
      p_wr_idx     = rd_idx_ff[AW-1:0];
      p_wr_data    = pnew_ff;
      s_rd_en      = 1'b0;
      s_rd_idx     = idx_ff[AW-1:0];
      s_wr_en      = 1'b0;
      s_wr_push    = 1'b0;
      s_wr_idx     = sh_next[AW-1:0];
      s_wr_data    = s_q;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               page_in   = req_access_address[PAGE_LSB +: PAGE_W];
               wflag_in  = req_is_write;
               frames_in = frames_clamp;
               prod_in   = PROD_W'(frames_clamp) * PROD_W'(pct_clamp);
               dread_in  = 1'b0;
               dwrite_in = 1'b0;
               hit_in    = HIT_MISS;
               state_in  = ST_SHARE;
            end
         end
         ST_SHARE: begin
            sec_share_in = sec_calc;
            pri_share_in = frames_ff - sec_calc;
            idx_in       = '0;
            rd_valid_in  = 1'b0;
            state_in     = ST_PSCAN;
         end
         ST_PSCAN: begin
            if (rd_valid_ff && (p_q.page == page_ff)) begin
               if (wflag_ff) begin
                  p_wr_en   = 1'b1;
                  p_wr_idx  = rd_idx_ff[AW-1:0];
                  p_wr_data = '{page: page_ff, dirty: 1'b1};
               end
               hit_in      = HIT_PRIMARY;
               rd_valid_in = 1'b0;
               state_in    = ST_FINISH;
            end else if ((p_used_ff == '0) || (rd_valid_ff && (rd_idx_ff == p_last))) begin
               rd_valid_in = 1'b0;
               if (CW'(p_used_ff) < CW'(pri_share_ff)) begin
                  p_wr_en   = 1'b1;
                  p_wr_push = 1'b1;
                  p_wr_data = '{page: page_ff, dirty: wflag_ff};
                  p_head_in = p_head_dec;
                  p_used_in = p_used_ff + UW'(1);
                  dread_in  = 1'b1;
                  state_in  = ST_FINISH;
               end else begin
                  p_rd_en  = 1'b1;
                  p_rd_idx = p_last[AW-1:0];
                  state_in = ST_PTAIL;
               end
            end else if (idx_ff < p_used_ff) begin
               p_rd_en     = 1'b1;
               p_rd_idx    = idx_ff[AW-1:0];
               rd_valid_in = 1'b1;
               rd_idx_in   = idx_ff;
               idx_in      = idx_ff + UW'(1);
            end else begin
               rd_valid_in = 1'b0;
            end
         end
         ST_PTAIL: begin
            tail_in     = p_q;
            idx_in      = '0;
            rd_valid_in = 1'b0;
            state_in    = ST_SSCAN;
         end
         ST_SSCAN: begin
            if (rd_valid_ff && (s_q.page == page_ff)) begin
               pnew_in     = '{page: s_q.page, dirty: s_q.dirty | wflag_ff};
               hit_in      = HIT_SECONDARY;
               rd_valid_in = 1'b0;
               if (rd_idx_ff == '0) begin
                  state_in = ST_PUSH;
               end else begin
                  sh_idx_in = rd_idx_ff - UW'(1);
                  state_in  = ST_SHIFT_RD;
               end
            end else if ((s_used_ff == '0) || (rd_valid_ff && (rd_idx_ff == s_last))) begin
               rd_valid_in = 1'b0;
               pnew_in     = '{page: page_ff, dirty: wflag_ff};
               dread_in    = 1'b1;
               if ((s_used_ff != '0) && (CW'(s_used_ff) >= CW'(sec_share_ff))) begin
                  s_rd_en  = 1'b1;
                  s_rd_idx = s_last[AW-1:0];
                  state_in = ST_STAIL;
               end else begin
                  state_in = ST_PUSH;
               end
            end else if (idx_ff < s_used_ff) begin
               s_rd_en     = 1'b1;
               s_rd_idx    = idx_ff[AW-1:0];
               rd_valid_in = 1'b1;
               rd_idx_in   = idx_ff;
               idx_in      = idx_ff + UW'(1);
            end else begin
               rd_valid_in = 1'b0;
            end
         end
         ST_STAIL: begin
            dwrite_in = s_q.dirty;
            s_used_in = s_last;
            state_in  = ST_PUSH;
         end
         ST_SHIFT_RD: begin
            s_rd_en  = 1'b1;
            s_rd_idx = sh_idx_ff[AW-1:0];
            state_in = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            s_wr_en   = 1'b1;
            s_wr_idx  = sh_next[AW-1:0];
            s_wr_data = s_q;
            if (sh_idx_ff == '0) begin
               state_in = ST_PUSH;
            end else begin
               sh_idx_in = sh_idx_ff - UW'(1);
               state_in  = ST_SHIFT_RD;
            end
         end
         ST_PUSH: begin
            p_wr_en   = 1'b1;
            p_wr_push = 1'b1;
            p_wr_data = pnew_ff;
            p_head_in = p_head_dec;
            s_wr_en   = 1'b1;
            s_wr_data = tail_ff;
            if (hit_ff == HIT_SECONDARY) begin
               s_wr_idx = '0;
            end else begin
               s_wr_push = 1'b1;
               s_head_in = s_head_dec;
               s_used_in = s_used_ff + UW'(1);
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      reads_in      = reads_ff;
      writes_in     = writes_ff;
      accesses_in   = accesses_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_dread_in  = rsp_dread_ff;
      rsp_dwrite_in = rsp_dwrite_ff;
      rsp_hit_in    = rsp_hit_ff;
      if (rsp_load) begin
         if (dread_ff && (reads_ff != '1)) begin
            reads_in = reads_ff + CNT_W'(1);
         end
         if (dwrite_ff && (writes_ff != '1)) begin
            writes_in = writes_ff + CNT_W'(1);
         end
         if (accesses_ff != '1) begin
            accesses_in = accesses_ff + CNT_W'(1);
         end
         rsp_valid_in  = 1'b1;
         rsp_dread_in  = dread_ff;
         rsp_dwrite_in = dwrite_ff;
         rsp_hit_in    = hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         frames_cfg_ff <= 7'd64;
         pct_cfg_ff    <= 7'd50;
         p_head_ff     <= '0;
         s_head_ff     <= '0;
         p_used_ff     <= '0;
         s_used_ff     <= '0;
         rd_valid_ff   <= 1'b0;
         reads_ff      <= '0;
         writes_ff     <= '0;
         accesses_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         frames_cfg_ff <= frames_cfg_in;
         pct_cfg_ff    <= pct_cfg_in;
         p_head_ff     <= p_head_in;
         s_head_ff     <= s_head_in;
         p_used_ff     <= p_used_in;
         s_used_ff     <= s_used_in;
         rd_valid_ff   <= rd_valid_in;
         reads_ff      <= reads_in;
         writes_ff     <= writes_in;
         accesses_ff   <= accesses_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      wflag_ff      <= wflag_in;
      frames_ff     <= frames_in;
      prod_ff       <= prod_in;
      sec_share_ff  <= sec_share_in;
      pri_share_ff  <= pri_share_in;
      idx_ff        <= idx_in;
      rd_idx_ff     <= rd_idx_in;
      sh_idx_ff     <= sh_idx_in;
      tail_ff       <= tail_in;
      pnew_ff       <= pnew_in;
      dread_ff      <= dread_in;
      dwrite_ff     <= dwrite_in;
      hit_ff        <= hit_in;
      rsp_dread_ff  <= rsp_dread_in;
      rsp_dwrite_ff <= rsp_dwrite_in;
      rsp_hit_ff    <= rsp_hit_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_disk_read       = rsp_dread_ff;
   assign rsp_disk_write      = rsp_dwrite_ff;
   assign rsp_hit_place       = rsp_hit_ff;
   assign rsp_reads_so_far    = reads_ff;
   assign rsp_writes_so_far   = writes_ff;
   assign rsp_accesses_so_far = accesses_ff;

   `SFPR_ASSERT_NOW(a_used_bound, 1'b1,
      (CW'(p_used_ff) <= CW'(MAX_FRAMES)) && (CW'(s_used_ff) <= CW'(MAX_FRAMES)))
   `SFPR_ASSERT_NOW(a_write_on_miss, rsp_valid_ff && rsp_dwrite_ff,
      rsp_dread_ff && (rsp_hit_ff == HIT_MISS))
   `SFPR_ASSERT_NOW(a_read_iff_miss, rsp_valid_ff,
      rsp_dread_ff == (rsp_hit_ff == HIT_MISS))
   `SFPR_ASSERT_NEXT(a_load_counts, rsp_load && (accesses_ff != '1),
      accesses_ff == $past(accesses_ff) + CNT_W'(1))

endmodule

@@ hw/rtl/sfpr_ring.sv @@
// Ring-addressed list store: one synchronous memory, logical-to-physical mapping.
// Depends on sfpr_pkg.
module sfpr_ring
   import sfpr_pkg::*;
#(
   parameter int MAX_FRAMES = 64
) (
   input  logic                          clock,
   input  logic [$clog2(MAX_FRAMES)-1:0] head,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_FRAMES)-1:0] rd_idx,
   output entry_type                     rd_data,
   input  logic                          wr_en,
   input  logic                          wr_push,
   input  logic [$clog2(MAX_FRAMES)-1:0] wr_idx,
   input  entry_type                     wr_data
);

   localparam int AW = $clog2(MAX_FRAMES);

   entry_type mem [MAX_FRAMES];
   entry_type rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [AW:0]   rd_sum;
   logic [AW:0]   wr_sum;

   always_comb begin
      rd_sum = {1'b0, head} + {1'b0, rd_idx};
      if (rd_sum >= (AW+1)'(MAX_FRAMES)) begin
         rd_sum = rd_sum - (AW+1)'(MAX_FRAMES);
      end
      rd_addr = rd_sum[AW-1:0];
      wr_sum = {1'b0, head} + {1'b0, wr_idx};
      if (wr_sum >= (AW+1)'(MAX_FRAMES)) begin
         wr_sum = wr_sum - (AW+1)'(MAX_FRAMES);
      end
      if (wr_push) begin
         wr_addr = (head == '0) ? AW'(MAX_FRAMES - 1) : head - AW'(1);
      end else begin
         wr_addr = wr_sum[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
